// ----- hdl/tkat_pkg.sv -----
package tkat_pkg;

    localparam int TKAT_SLOTS_DEF = 32;
    localparam int RANK_W         = 6;
    localparam int KEY_W          = 32;
    localparam int VALUE_W        = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DUMP   = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] amount;
    } cmd_word_t;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [KEY_W-1:0]   entry_key;
        logic [VALUE_W-1:0] entry_value;
        logic               occupied;
        logic               last_of_dump;
    } result_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

endpackage

// ----- hdl/tkat_mem.sv -----
module tkat_mem #(
    parameter int SLOTS  = tkat_pkg::TKAT_SLOTS_DEF,
    parameter int ADDR_W = $clog2(SLOTS)
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  tkat_pkg::entry_t    wr_data,
    input  logic [ADDR_W-1:0]   rd_addr,
    output tkat_pkg::entry_t    rd_data
);
    import tkat_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/tkat_ctrl.sv -----
module tkat_ctrl #(
    parameter int SLOTS  = tkat_pkg::TKAT_SLOTS_DEF,
    parameter int ADDR_W = $clog2(SLOTS),
    parameter int CNT_W  = $clog2(SLOTS + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tkat_pkg::cmd_word_t    cmd,
    output logic                   result_strobe,
    output tkat_pkg::result_word_t result,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output tkat_pkg::entry_t       wr_data,
    output logic [ADDR_W-1:0]      rd_addr,
    input  tkat_pkg::entry_t       rd_data
);
    import tkat_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_NEW_DEC,
        S_SH_RD,
        S_SH_WR,
        S_ACC_RD,
        S_ACC_CHK,
        S_PUT,
        S_DUMP
    } state_t;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              occupied;
        logic              last;
    } dump_tag_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic                 pos_set_reg, pos_set_next;
    logic                 is_new_reg, is_new_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic [VALUE_W-1:0]   amt_reg, amt_next;
    logic                 strobe_reg, strobe_next;
    dump_tag_t            tag_reg, tag_next;

    logic [VALUE_W:0]     sum_wide;
    logic [VALUE_W-1:0]   sum_sat;
    logic [CNT_W-1:0]     idx_dec;
    logic [CNT_W-1:0]     pos_dec;

    assign sum_wide = {1'b0, rd_data.value} + {1'b0, amt_reg};
    assign sum_sat  = sum_wide[VALUE_W] ? {VALUE_W{1'b1}} : sum_wide[VALUE_W-1:0];
    assign idx_dec  = idx_reg - CNT_W'(1);
    assign pos_dec  = pos_reg - CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        pos_set_next = pos_set_reg;
        is_new_next  = is_new_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        amt_next     = amt_reg;
        strobe_next  = 1'b0;
        tag_next     = tag_reg;
        wr_en        = 1'b0;
        wr_addr      = pos_reg[ADDR_W-1:0];
        wr_data      = rd_data;
        rd_addr      = idx_reg[ADDR_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next     = '0;
                    pos_set_next = 1'b0;
                    key_next     = cmd.key;
                    amt_next     = cmd.amount;
                    priority if (cmd.op == OP_INSERT)
                    begin
                        state_next = (count_reg == '0) ? S_NEW_DEC : S_SCAN_RD;
                    end
                    else if (cmd.op == OP_DUMP)
                    begin
                        state_next = S_DUMP;
                    end
                    else if (cmd.op == OP_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        // unused op code: drop the word
                    end
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (rd_data.key == key_reg)
                begin
                    // hit: add, then bubble the entry up
                    amt_next    = sum_sat;
                    pos_next    = idx_reg;
                    is_new_next = 1'b0;
                    state_next  = S_ACC_RD;
                end
                else
                begin
                    if (!pos_set_reg && (rd_data.value < amt_reg))
                    begin
                        pos_next     = idx_reg;
                        pos_set_next = 1'b1;
                    end
                    if (idx_reg == count_reg - CNT_W'(1))
                    begin
                        state_next = S_NEW_DEC;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_NEW_DEC:
            begin
                is_new_next = 1'b1;
                if (!pos_set_reg && (count_reg == CNT_W'(SLOTS)))
                begin
                    // ranks below every entry of a full table: drop
                    state_next = S_IDLE;
                end
                else
                begin
                    if (!pos_set_reg)
                    begin
                        pos_next = count_reg;
                    end
                    idx_next   = (count_reg == CNT_W'(SLOTS)) ? CNT_W'(SLOTS - 1) : count_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                rd_addr = idx_dec[ADDR_W-1:0];
                if (idx_reg > pos_reg)
                begin
                    state_next = S_SH_WR;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_SH_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg[ADDR_W-1:0];
                wr_data    = rd_data;
                idx_next   = idx_dec;
                state_next = S_SH_RD;
            end
            S_ACC_RD:
            begin
                rd_addr = pos_dec[ADDR_W-1:0];
                state_next = (pos_reg == '0) ? S_PUT : S_ACC_CHK;
            end
            S_ACC_CHK:
            begin
                if (amt_reg > rd_data.value)
                begin
                    // move the smaller neighbor down one slot
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg[ADDR_W-1:0];
                    wr_data    = rd_data;
                    pos_next   = pos_dec;
                    state_next = S_ACC_RD;
                end
                else
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[ADDR_W-1:0];
                wr_data.key   = key_reg;
                wr_data.value = amt_reg;
                if (is_new_reg && (count_reg != CNT_W'(SLOTS)))
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                state_next = S_IDLE;
            end
            S_DUMP:
            begin
                strobe_next       = 1'b1;
                tag_next.rank     = RANK_W'(idx_reg);
                tag_next.occupied = idx_reg < count_reg;
                tag_next.last     = idx_reg == CNT_W'(SLOTS - 1);
                if (idx_reg == CNT_W'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            strobe_reg  <= 1'b0;
            pos_set_reg <= 1'b0;
            is_new_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            strobe_reg  <= strobe_next;
            pos_set_reg <= pos_set_next;
            is_new_reg  <= is_new_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        pos_reg <= pos_next;
        key_reg <= key_next;
        amt_reg <= amt_next;
        tag_reg <= tag_next;
    end

    assign busy                 = state_reg != S_IDLE;
    assign result_strobe        = strobe_reg;
    assign result.rank          = tag_reg.rank;
    assign result.entry_key     = tag_reg.occupied ? rd_data.key : '0;
    assign result.entry_value   = tag_reg.occupied ? rd_data.value : '0;
    assign result.occupied      = tag_reg.occupied;
    assign result.last_of_dump  = tag_reg.last;

endmodule

// ----- hdl/top_k_accumulating_table_top.sv -----
// Insert: each occupied slot scanned takes a read and a check state, each slot
//   moved a read and a write state, then a put state writes the entry.
// Dump: one word per cycle, TABLE_SLOTS words. Clear: zeroes the entry count.
// One command at a time; start is taken only while busy is low.
// Reset clears control state and the entry count; table contents stay stale and
//   are masked by the count. The receiver cannot stall result words.
module top_k_accumulating_table_top #(
    parameter int TABLE_SLOTS = tkat_pkg::TKAT_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  tkat_pkg::cmd_word_t    cmd,
    output logic                   result_strobe,
    output tkat_pkg::result_word_t result
);
    import tkat_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

    // Table port traffic between the sequencer and the entry store
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;

    // Sequencer: scan for the key, then bubble a hit up or shift room for a new
    // key; drive out one slot per cycle on a dump
    tkat_ctrl #(
        .SLOTS  (TABLE_SLOTS),
        .ADDR_W (ADDR_W),
        .CNT_W  (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .result_strobe (result_strobe),
        .result        (result),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data)
    );

    // Entry store: {key, value} per slot in rank order, registered read
    tkat_mem #(
        .SLOTS  (TABLE_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

// ----- hdl/tkat_checker.sv -----
module tkat_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   busy,
    input logic                   result_strobe,
    input tkat_pkg::result_word_t result
);
    import tkat_pkg::*;

    // Words come only out of a dump in progress
    a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy))
        else $error("result word without a dump in progress");

    // A dump streams without gaps until its last word
    a_dump_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.last_of_dump) |=> result_strobe)
        else $error("gap inside a dump");

    // Ranks advance by one within a dump
    a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && $past(result_strobe) && !$past(result.last_of_dump))
        |-> (result.rank == RANK_W'($past(result.rank) + 1'b1)))
        else $error("rank did not advance by one");

    // Empty slots read as zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.occupied)
        |-> (result.entry_key == '0 && result.entry_value == '0))
        else $error("empty slot carries data");

    // Once a slot is empty, all later slots of the dump are empty
    a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.occupied && !result.last_of_dump)
        |=> !result.occupied)
        else $error("occupied slot after an empty one");

endmodule

bind top_k_accumulating_table_top tkat_checker u_tkat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .busy          (busy),
    .result_strobe (result_strobe),
    .result        (result)
);

// ----- bench/tb_top_k_accumulating_table_top.sv -----
`timescale 1ns / 100ps

module tb_top_k_accumulating_table_top;

    import tkat_pkg::*;

    localparam int SLOTS     = TKAT_SLOTS_DEF;
    localparam int KEY_POOL  = 48;
    localparam int MAX_PRINT = 30;
    // Long enough for the slowest insert, plus margin at the end.
    localparam int DRAIN_CYCLES = 4 * SLOTS + 16;
    // Op code the block does not define; it must be ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    cmd_word_t    cmd   = '0;
    logic         busy;
    logic         result_strobe;
    result_word_t result;

    // Commands waiting for the driver, in issue order.
    cmd_word_t    cmd_queue[$];
    // Dump words the table should still produce, oldest first.
    result_word_t dump_words_due[$];

    // Shadow copy of the sorted table.
    entry_t       shadow_tbl[SLOTS];
    int           shadow_count = 0;

    logic [KEY_W-1:0] key_pool[KEY_POOL];

    int send_idle_pct  = 0;
    int items_queued   = 0;
    int words_checked  = 0;
    int dumps_taken    = 0;
    int full_dumps     = 0;
    int dropped_keys   = 0;
    int saturations    = 0;
    int err_count      = 0;

    top_k_accumulating_table_top #(
        .TABLE_SLOTS(SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_strobe(result_strobe),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Assert reset once at the start, then leave it released.
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard limit on run length; the slowest legal run is far below this.
    initial
    begin
        #2_000_000;
        $display("FAIL top_k_accumulating_table_top");
        $finish;
    end

    // Apply one accepted command to the shadow table and queue any dump words it causes.
    task automatic table_update(input cmd_word_t c);
        int           hit;
        int           pos;
        int           i;
        logic [32:0]  sum;
        entry_t       tmp;
        result_word_t w;
        logic         occ;
        hit = -1;
        case (c.op)
            OP_INSERT:
            begin
                for (i = 0; i < shadow_count; i++)
                    if (hit < 0 && shadow_tbl[i].key == c.key)
                        hit = i;
                if (hit >= 0)
                begin
                    // Known key: add with saturation, then bubble up past strictly smaller values.
                    sum = {1'b0, shadow_tbl[hit].value} + {1'b0, c.amount};
                    if (sum[32])
                        saturations++;
                    shadow_tbl[hit].value = sum[32] ? '1 : sum[VALUE_W-1:0];
                    pos = hit;
                    while (pos > 0 && shadow_tbl[pos].value > shadow_tbl[pos-1].value)
                    begin
                        tmp               = shadow_tbl[pos];
                        shadow_tbl[pos]   = shadow_tbl[pos-1];
                        shadow_tbl[pos-1] = tmp;
                        pos--;
                    end
                end
                else
                begin
                    // New key: land after every entry of equal or larger value.
                    pos = 0;
                    while (pos < shadow_count && shadow_tbl[pos].value >= c.amount)
                        pos++;
                    if (pos >= SLOTS)
                        dropped_keys++;
                    else
                    begin
                        // Shift down; on a full table the last entry falls off.
                        for (i = (shadow_count < SLOTS) ? shadow_count : SLOTS - 1;
                             i > pos; i--)
                            shadow_tbl[i] = shadow_tbl[i-1];
                        shadow_tbl[pos].key   = c.key;
                        shadow_tbl[pos].value = c.amount;
                        if (shadow_count < SLOTS)
                            shadow_count++;
                    end
                end
            end
            OP_DUMP:
            begin
                dumps_taken++;
                if (shadow_count == SLOTS)
                    full_dumps++;
                for (i = 0; i < SLOTS; i++)
                begin
                    occ              = (i < shadow_count);
                    w.rank           = i[RANK_W-1:0];
                    w.entry_key      = occ ? shadow_tbl[i].key : '0;
                    w.entry_value    = occ ? shadow_tbl[i].value : '0;
                    w.occupied       = occ;
                    w.last_of_dump   = (i == SLOTS - 1);
                    dump_words_due.push_back(w);
                end
            end
            OP_CLEAR:
            begin
                shadow_count = 0;
                for (i = 0; i < SLOTS; i++)
                    shadow_tbl[i] = '0;
            end
            default:
            begin
                // Unused op code: drop it, no state change.
            end
        endcase
    endtask

    // Driver: hold a pending word until it is taken, then advance to the next one.
    always @(posedge clk or negedge rst_n)
    begin : drive_cmds
        logic taken;
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd   <= '0;
        end
        else
        begin
            taken = start && !busy;
            if (taken)
                table_update(cmd);
            if (start && !taken)
            begin
                // Hold start and cmd until the block takes the word.
            end
            else if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                start <= 1'b1;
                cmd   <= cmd_queue.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            err_count++;
            if (err_count <= MAX_PRINT)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    // Monitor: every strobed word must match the oldest due dump word.
    always @(posedge clk)
    begin : watch_words
        result_word_t exp_w;
        if (rst_n && result_strobe)
        begin
            if (dump_words_due.size() == 0)
            begin
                err_count++;
                if (err_count <= MAX_PRINT)
                    $display("%0t: unexpected word, expected none, actual %h", $time, result);
            end
            else
            begin
                exp_w = dump_words_due.pop_front();
                words_checked++;
                check_field("rank",         32'(exp_w.rank),         32'(result.rank));
                check_field("entry_key",    exp_w.entry_key,         result.entry_key);
                check_field("entry_value",  exp_w.entry_value,       result.entry_value);
                check_field("occupied",     32'(exp_w.occupied),     32'(result.occupied));
                check_field("last_of_dump", 32'(exp_w.last_of_dump),
                            32'(result.last_of_dump));
            end
        end
    end

    task automatic queue_cmd(input logic [1:0] op, input logic [KEY_W-1:0] key,
                             input logic [VALUE_W-1:0] amount);
        cmd_word_t c;
        c.op     = op;
        c.key    = key;
        c.amount = amount;
        cmd_queue.push_back(c);
        // The unused op code is ignored by the block; do not count it as stimulus.
        if (op != OP_UNUSED)
            items_queued++;
    endtask

    // Mix zero, small equal-prone, mid-range, full-range and near-saturation amounts.
    function automatic logic [VALUE_W-1:0] pick_amount();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return $urandom_range(0, 7) << 16;
            2:       return $urandom_range(0, 255) << 16;
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
            4:       return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Mostly reuse keys so entries accumulate; now and then bring in a fresh one.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_pool[$urandom_range(0, KEY_POOL - 1)];
    endfunction

    // One well-formed round: optional clear, a run of inserts, a closing dump.
    task automatic queue_round(input int inserts);
        int n;
        if ($urandom_range(0, 3) == 0)
            queue_cmd(OP_CLEAR, $urandom, $urandom);
        for (n = 0; n < inserts; n++)
        begin
            queue_cmd(OP_INSERT, pick_key(), pick_amount());
            if ($urandom_range(0, 19) == 0)
                queue_cmd(OP_UNUSED, $urandom, $urandom);
        end
        queue_cmd(OP_DUMP, $urandom, $urandom);
    endtask

    task automatic wait_all_taken();
        while (cmd_queue.size() != 0 || start)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int idle_plan[4];
        int ph;
        int target;
        int n;
        idle_plan = '{0, 72, 32, 0};
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < KEY_POOL; n++)
            key_pool[n] = $urandom;

        @(posedge rst_n);

        // Directed: empty table, key zero, extremes, ties, passing, saturation, unused op.
        queue_cmd(OP_DUMP,   32'h0000_0000, 32'h0000_0000);
        queue_cmd(OP_INSERT, 32'h0000_0000, 32'h0005_0000);
        queue_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_INSERT, 32'h1234_5678, 32'h0005_0000);
        queue_cmd(OP_INSERT, 32'h1234_5678, 32'h0001_0000);
        queue_cmd(OP_INSERT, 32'hA5A5_5A5A, 32'h0006_0000);
        queue_cmd(OP_INSERT, 32'h0000_0000, 32'h0001_0000);
        queue_cmd(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0001);
        queue_cmd(OP_INSERT, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
        queue_cmd(OP_INSERT, 32'h0000_0001, 32'h0000_0000);
        queue_cmd(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_DUMP,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(OP_CLEAR,  32'h5A5A_A5A5, 32'h0000_0000);
        queue_cmd(OP_DUMP,   32'h0000_0000, 32'hFFFF_FFFF);
        queue_cmd(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
        queue_cmd(OP_DUMP,   32'h0000_0000, 32'h0000_0000);

        // Fill past capacity so the last entry gets pushed out and low keys dropped.
        queue_cmd(OP_CLEAR, '0, '0);
        for (n = 0; n < SLOTS + 8; n++)
            queue_cmd(OP_INSERT, key_pool[n], pick_amount());
        queue_cmd(OP_INSERT, 32'h0BAD_0BAD, 32'h0000_0000);
        queue_cmd(OP_DUMP, '0, '0);

        // Random rounds, one idle setting per phase.
        for (ph = 0; ph < 4; ph++)
        begin
            wait_all_taken();
            send_idle_pct = idle_plan[ph];
            target        = items_queued + 24;
            while (items_queued < target)
                queue_round($urandom_range(1, SLOTS + 12));
        end

        wait_all_taken();
        while (dump_words_due.size() != 0)
            @(posedge clk);
        // Let any stray word surface before judging.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands, %0d dumps (%0d of a full table), %0d words checked.",
                 items_queued, dumps_taken, full_dumps, words_checked);
        $display("Saw %0d saturating adds and %0d new keys dropped from a full table.",
                 saturations, dropped_keys);
        if (err_count == 0)
            $display("PASS top_k_accumulating_table_top");
        else
            $display("FAIL top_k_accumulating_table_top");
        $finish;
    end

endmodule
